@@ design/eomr_pkg.sv @@
// shared types and constants for the edit offset remap table
`timescale 1ns / 1ps

package eomr_pkg;

   // default number of edit points held in the table
   localparam int DEFAULT_MAX_ENTRIES = 64;

   // request function codes
   localparam logic [1:0] FUNC_INSERT  = 2'd0;
   localparam logic [1:0] FUNC_FORWARD = 2'd1;
   localparam logic [1:0] FUNC_INVERSE = 2'd2;

   // one request item
   typedef struct packed {
      logic [1:0]         func;
      logic [30:0]        position;
      logic signed [31:0] shift_amount;
   } req_type;

   // one response item
   typedef struct packed {
      logic signed [31:0] mapped_position;
      logic               table_full;
   } rsp_type;

   // insert command broadcast to every cell
   typedef struct packed {
      logic        en;
      logic [30:0] position;
      logic [31:0] shift;
   } ins_cmd_type;

   // entry handed from one cell to its right neighbor during an insert
   typedef struct packed {
      logic        keep;
      logic [30:0] loc;
      logic [31:0] shift;
   } link_type;

   // query token walking down the chain
   typedef struct packed {
      logic        valid;
      logic        active;
      logic        inv;
      logic [30:0] pos;
      logic [31:0] sum;
   } token_type;

endpackage

@@ design/eomr_cell.sv @@
// one cell of the edit point chain: holds one entry and one token stage
`timescale 1ns / 1ps

module eomr_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 used,
   input  eomr_pkg::ins_cmd_type ins,
   input  eomr_pkg::link_type    prev_link,
   output eomr_pkg::link_type    link_out,
   input  eomr_pkg::token_type   tok_in,
   output eomr_pkg::token_type   tok_out
);

   logic [30:0]         loc_ff;
   logic [31:0]         shift_ff;
   logic                keep;
   eomr_pkg::token_type tok_ff;
   eomr_pkg::token_type tok_in_next;
   logic [31:0]         sum_next;
   logic                stop;
   logic                take;

   // entry stays put when it lies strictly below the new location
   assign keep = used && (loc_ff < ins.position);

   assign link_out.keep  = keep;
   assign link_out.loc   = loc_ff;
   assign link_out.shift = shift_ff;

   // insert: first non-kept cell takes the new entry, the rest shift right
   always_ff @(posedge clock) begin
      if (ins.en && !keep) begin
         if (prev_link.keep) begin
            loc_ff   <= ins.position;
            shift_ff <= ins.shift;
         end else begin
            loc_ff   <= prev_link.loc;
            shift_ff <= prev_link.shift;
         end
      end
   end

   // walk step: add this entry's shift unless the walk stops here
   assign sum_next = tok_in.sum + shift_ff;
   assign stop     = !used || (loc_ff > tok_in.pos) ||
                     (tok_in.inv && (sum_next > {1'b0, tok_in.pos}));
   assign take     = tok_in.active && !stop;

   always_comb begin
      tok_in_next        = tok_in;
      tok_in_next.active = take;
      tok_in_next.sum    = take ? sum_next : tok_in.sum;
   end

   // token stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in_next.valid;
      end
      tok_ff.active <= tok_in_next.active;
      tok_ff.inv    <= tok_in_next.inv;
      tok_ff.pos    <= tok_in_next.pos;
      tok_ff.sum    <= tok_in_next.sum;
   end

   assign tok_out = tok_ff;

endmodule

@@ design/edit_offset_remap_table.sv @@
// top level of the edit offset remap table
`timescale 1ns / 1ps

// Keeps up to MAX_ENTRIES edit points sorted by location, one per cell of a
// chain. A request on req_data (valid/stall handshake) is an insert, a
// forward map or an inverse map; every request gives exactly one response on
// rsp_data. One request is worked on at a time: req_stall is high from the
// accepting edge until the response has been loaded into the output register.
// An insert is written into all cells at the accepting edge (parallel compare,
// neighbor shift) and its response goes through the result register into the
// output register; an insert on a full table is dropped and answered with
// table_full set. A map query sends a token down the chain, one cell per
// cycle, carrying the running sum; its response is formed from the sum once
// the token leaves the last cell. When the receiver stalls, the response
// waits in the output register and a finished next response waits in a
// holding register until the output frees. Reset empties the table (entry
// count zero) and drops any request in flight.

module edit_offset_remap_table #(
   parameter int MAX_ENTRIES = eomr_pkg::DEFAULT_MAX_ENTRIES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  eomr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output eomr_pkg::rsp_type rsp_data
);

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   eomr_pkg::rsp_type      res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   eomr_pkg::rsp_type      rsp_data_ff, rsp_data_in;
   logic                   accept;
   logic                   is_query;
   logic                   full;
   eomr_pkg::ins_cmd_type  ins;
   eomr_pkg::link_type     head_link;
   eomr_pkg::link_type     links [MAX_ENTRIES];
   eomr_pkg::token_type    toks [MAX_ENTRIES+1];
   logic [MAX_ENTRIES-1:0] tok_valid_vec;
   eomr_pkg::token_type    last_tok;
   logic [31:0]            pos_ext;
   logic [31:0]            mapped;

   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign full     = (count_ff == CNT_W'(MAX_ENTRIES));
   assign is_query = (req_data.func == eomr_pkg::FUNC_FORWARD) ||
                     (req_data.func == eomr_pkg::FUNC_INVERSE);

   // insert command to all cells
   assign ins.en       = accept && (req_data.func == eomr_pkg::FUNC_INSERT) && !full;
   assign ins.position = req_data.position;
   assign ins.shift    = $unsigned(req_data.shift_amount);

   // left end of the chain: the first cell takes the new entry unless kept
   assign head_link.keep  = 1'b1;
   assign head_link.loc   = '0;
   assign head_link.shift = '0;

   // token launched into the first cell
   assign toks[0].valid  = accept && is_query;
   assign toks[0].active = 1'b1;
   assign toks[0].inv    = (req_data.func == eomr_pkg::FUNC_INVERSE);
   assign toks[0].pos    = req_data.position;
   assign toks[0].sum    = '0;

   // row of cells
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      logic used;
      assign used = (CNT_W'(i) < count_ff);
      if (i == 0) begin : g_first
         eomr_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .used      (used),
            .ins       (ins),
            .prev_link (head_link),
            .link_out  (links[i]),
            .tok_in    (toks[i]),
            .tok_out   (toks[i+1])
         );
      end else begin : g_rest
         eomr_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .used      (used),
            .ins       (ins),
            .prev_link (links[i-1]),
            .link_out  (links[i]),
            .tok_in    (toks[i]),
            .tok_out   (toks[i+1])
         );
      end
      assign tok_valid_vec[i] = toks[i+1].valid;
   end

   // final mapping once the token leaves the last cell
   assign last_tok = toks[MAX_ENTRIES];
   assign pos_ext  = {1'b0, last_tok.pos};
   assign mapped   = last_tok.inv ? (pos_ext - last_tok.sum) : (pos_ext + last_tok.sum);

   // sequencer, entry count and pending response
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_in.mapped_position = '0;
               res_in.table_full      = 1'b0;
               if (req_data.func == eomr_pkg::FUNC_INSERT) begin
                  res_in.table_full = full;
                  if (!full) begin
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               state_in = is_query ? ST_WALK : ST_DONE;
            end
         end
         ST_WALK: begin
            if (last_tok.valid) begin
               res_in.mapped_position = $signed(mapped);
               res_in.table_full      = 1'b0;
               state_in               = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks

   // table never holds more entries than cells
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count exceeds table size");

   // at most one token walks the chain
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $countones(tok_valid_vec) <= 1)
      else $error("more than one token in the chain");

   // a token reaches the end only while the sequencer waits for it
   a_token_state: assert property (@(posedge clock) disable iff (reset)
      last_tok.valid |-> (state_ff == ST_WALK))
      else $error("token left the chain outside the walk state");

   // a dropped insert is only reported once the table is full
   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.table_full) |-> full)
      else $error("table_full reported on a table with free cells");

   // an accepted request makes the block busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("request accepted without leaving idle");

endmodule

@@ tb/sv/testbench.sv @@
// self-checking testbench for the edit offset remap table
`timescale 1ns / 1ps

module testbench;

   localparam int TABLE_DEPTH = eomr_pkg::DEFAULT_MAX_ENTRIES;
   localparam int STALL_LIMIT = 4000;
   localparam int PHASE_ITEMS = 145;

   // selector value that the block must ignore
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   localparam logic [30:0] POS_MAX   = 31'h7fff_ffff;
   localparam logic [31:0] SHIFT_MAX = 32'h7fff_ffff;
   localparam logic [31:0] SHIFT_MIN = 32'h8000_0000;

   // edit table mirror: predicts each response and matches it in order
   class edit_table_tracker;
      logic [30:0] loc_tab[TABLE_DEPTH];
      logic [31:0] shift_tab[TABLE_DEPTH];
      int unsigned n_points;
      eomr_pkg::rsp_type pending_results[$];
      int unsigned errors;
      int unsigned n_insert, n_dropped, n_forward, n_inverse, n_unused, n_checked;

      function new();
         n_points = 0;
         errors = 0;
         n_insert = 0;
         n_dropped = 0;
         n_forward = 0;
         n_inverse = 0;
         n_unused = 0;
         n_checked = 0;
      endfunction

      // update the table and work out the response of one request
      function eomr_pkg::rsp_type remap_result(eomr_pkg::req_type r);
         eomr_pkg::rsp_type res;
         logic [31:0] sum;
         logic [31:0] trial;
         int unsigned slot;
         res = '0;
         sum = '0;
         case (r.func)
            eomr_pkg::FUNC_INSERT: begin
               n_insert++;
               if (n_points >= TABLE_DEPTH) begin
                  res.table_full = 1'b1;
                  n_dropped++;
               end else begin
                  slot = 0;
                  while (slot < n_points && loc_tab[slot] < r.position) slot++;
                  for (int v = n_points; v > slot; v--) begin
                     loc_tab[v]   = loc_tab[v-1];
                     shift_tab[v] = shift_tab[v-1];
                  end
                  loc_tab[slot]   = r.position;
                  shift_tab[slot] = r.shift_amount;
                  n_points++;
               end
            end
            eomr_pkg::FUNC_FORWARD: begin
               n_forward++;
               for (int k = 0; k < n_points; k++) begin
                  if (loc_tab[k] > r.position) break;
                  sum = sum + shift_tab[k];
               end
               res.mapped_position = sum + {1'b0, r.position};
            end
            eomr_pkg::FUNC_INVERSE: begin
               n_inverse++;
               for (int k = 0; k < n_points; k++) begin
                  if (loc_tab[k] > r.position) break;
                  trial = sum + shift_tab[k];
                  if (trial > {1'b0, r.position}) break;
                  sum = trial;
               end
               res.mapped_position = {1'b0, r.position} - sum;
            end
            default: n_unused++;
         endcase
         return res;
      endfunction

      function void note_request(eomr_pkg::req_type r);
         pending_results.push_back(remap_result(r));
      endfunction

      function void check_response(eomr_pkg::rsp_type got);
         eomr_pkg::rsp_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response mapped_position=%h table_full=%b",
                     $time, got.mapped_position, got.table_full);
            errors++;
         end else begin
            want = pending_results.pop_front();
            n_checked++;
            if (got.mapped_position !== want.mapped_position) begin
               $display("%0t: mapped_position mismatch: expected %h, actual %h",
                        $time, want.mapped_position, got.mapped_position);
               errors++;
            end
            if (got.table_full !== want.table_full) begin
               $display("%0t: table_full mismatch: expected %b, actual %b",
                        $time, want.table_full, got.table_full);
               errors++;
            end
         end
      endfunction

      function int unsigned pending();
         return pending_results.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   eomr_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   eomr_pkg::rsp_type rsp_data;

   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned quiet_cycles = 0;

   edit_table_tracker board = new();

   edit_offset_remap_table #(
      .MAX_ENTRIES(TABLE_DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // random receiver stalls
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // check responses first, then record the request taken at the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) board.check_response(rsp_data);
         if (req_valid && !req_stall) board.note_request(req_data);
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("testbench NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic eomr_pkg::req_type build(logic [1:0] f, logic [30:0] p,
                                               logic [31:0] s);
      eomr_pkg::req_type r;
      r.func = f;
      r.position = p;
      r.shift_amount = s;
      return r;
   endfunction

   // random request, biased toward locations already in the table
   function automatic eomr_pkg::req_type random_request();
      logic [1:0]  f;
      logic [30:0] p;
      logic [31:0] s;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 16) f = eomr_pkg::FUNC_INSERT;
      else if (pick < 54) f = eomr_pkg::FUNC_FORWARD;
      else if (pick < 93) f = eomr_pkg::FUNC_INVERSE;
      else f = FUNC_UNUSED;
      case ($urandom_range(9))
         0, 1, 2: p = 31'($urandom);
         3, 4, 5: p = 31'($urandom_range(2000));
         6, 7, 8: begin
            if (board.n_points > 0)
               p = board.loc_tab[$urandom_range(board.n_points - 1)]
                   + 31'($urandom_range(6)) - 31'd3;
            else
               p = 31'($urandom_range(100));
         end
         default: p = $urandom_range(1) ? POS_MAX : '0;
      endcase
      case ($urandom_range(7))
         0, 1, 2: s = 32'($urandom_range(200)) - 32'd100;
         3, 4, 5: s = $urandom;
         6: begin
            case ($urandom_range(3))
               0: s = SHIFT_MAX;
               1: s = SHIFT_MIN;
               2: s = '1;
               default: s = '0;
            endcase
         end
         default: s = -32'($urandom_range(5000));
      endcase
      return build(f, p, s);
   endfunction

   // present one request, with random idle cycles before it
   task automatic send_request(input eomr_pkg::req_type r);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // hold off the sender until every response is back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   // empty table, unused selector, equal locations, extreme fields
   task automatic run_directed();
      send_request(build(eomr_pkg::FUNC_FORWARD, '0, '0));
      send_request(build(eomr_pkg::FUNC_INVERSE, POS_MAX, '1));
      send_request(build(eomr_pkg::FUNC_FORWARD, POS_MAX, '0));
      send_request(build(FUNC_UNUSED, POS_MAX, '1));
      send_request(build(eomr_pkg::FUNC_INSERT, 31'd100, 32'd5));
      send_request(build(eomr_pkg::FUNC_INSERT, 31'd100, -32'd3));
      send_request(build(eomr_pkg::FUNC_INSERT, '0, SHIFT_MAX));
      send_request(build(eomr_pkg::FUNC_INSERT, POS_MAX, SHIFT_MIN));
      send_request(build(eomr_pkg::FUNC_INSERT, 31'd50, 32'd10));
      send_request(build(eomr_pkg::FUNC_FORWARD, '0, '0));
      send_request(build(eomr_pkg::FUNC_FORWARD, 31'd49, '0));
      send_request(build(eomr_pkg::FUNC_FORWARD, 31'd50, '0));
      send_request(build(eomr_pkg::FUNC_FORWARD, 31'd100, '0));
      send_request(build(eomr_pkg::FUNC_FORWARD, POS_MAX, '0));
      send_request(build(eomr_pkg::FUNC_INVERSE, '0, '0));
      send_request(build(eomr_pkg::FUNC_INVERSE, 31'd60, '0));
      send_request(build(eomr_pkg::FUNC_INVERSE, 31'd100, '0));
      send_request(build(eomr_pkg::FUNC_INVERSE, 31'd110, '0));
      send_request(build(eomr_pkg::FUNC_INVERSE, POS_MAX, '0));
      send_request(build(FUNC_UNUSED, '0, '0));
   endtask

   // main sequence: directed part, then four pacing phases
   initial begin
      int unsigned idle_set[4];
      int unsigned stall_set[4];
      idle_set  = '{0, 48, 0, 11};
      stall_set = '{0, 0, 48, 11};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      drain();
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct  = idle_set[ph];
         stall_pct = stall_set[ph];
         repeat (PHASE_ITEMS) send_request(random_request());
         drain();
      end
      stall_pct = 0;
      repeat (TABLE_DEPTH + 8) @(posedge clock);
      $display("covered %0d inserts (%0d refused on a full table), %0d forward maps,",
               board.n_insert, board.n_dropped, board.n_forward);
      $display("%0d inverse maps, %0d unused selectors; %0d responses checked",
               board.n_inverse, board.n_unused, board.n_checked);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/eomr_pkg.sv
design/eomr_cell.sv
design/edit_offset_remap_table.sv
tb/sv/testbench.sv
